FILE: hdl/deq_pkg.sv
// Package for the double-ended queue: sizes, types, action codes and
// ring-pointer helpers. No dependencies.
package deq_pkg;

    localparam int CAPACITY = 1024;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int ENTRY_W  = 11;
    localparam int ACTION_W = 3;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_STATUS     = 3'd4
    } t_action;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    function automatic t_ptr ptr_inc(t_ptr p);
        ptr_inc = (p == t_ptr'(CAPACITY - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(t_ptr p);
        ptr_dec = (p == '0) ? t_ptr'(CAPACITY - 1) : p - t_ptr'(1);
    endfunction

endpackage

FILE: hdl/deq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/double_ended_queue.sv
// Top level of the double-ended queue: ring buffer in deq_ram with cached
// front and rear words. Depends on deq_pkg and deq_ram.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_action, i_push_value
//  out      from block o_out_valid / i_out_stall o_popped_value, o_popped_ok,
//                                                o_push_dropped, o_entry_count,
//                                                o_is_empty, o_front_value,
//                                                o_rear_value
//
// Each request is accepted in the idle state, which updates the pointers and
// issues the RAM access; the fetch state then takes the registered RAM read
// data that refreshes the cached front or rear word after a pop.
// A result waits in the output register; a stalled output holds the block in
// its fetch state. Reset is synchronous and empties the queue at once; the
// RAM contents are not cleared.
module double_ended_queue (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [deq_pkg::ACTION_W-1:0]          i_action,
    input  logic signed [deq_pkg::WORD_W-1:0]     i_push_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [deq_pkg::WORD_W-1:0]     o_popped_value,
    output logic                                  o_popped_ok,
    output logic                                  o_push_dropped,
    output logic [deq_pkg::ENTRY_W-1:0]           o_entry_count,
    output logic                                  o_is_empty,
    output logic signed [deq_pkg::WORD_W-1:0]     o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]     o_rear_value
);

    deq_pkg::t_state r_state, n_state;

    deq_pkg::t_ptr  r_head, n_head;
    deq_pkg::t_ptr  r_tail, n_tail;
    deq_pkg::t_cnt  r_count, n_count;
    deq_pkg::t_word r_front, n_front;
    deq_pkg::t_word r_rear, n_rear;
    deq_pkg::t_word r_popped, n_popped;
    logic           r_pop_ok, n_pop_ok;
    logic           r_dropped, n_dropped;
    logic           r_fix_front, n_fix_front;
    logic           r_fix_rear, n_fix_rear;

    logic           r_out_valid;
    deq_pkg::t_word r_out_popped;
    logic           r_out_pop_ok;
    logic           r_out_dropped;
    deq_pkg::t_cnt  r_out_count;
    deq_pkg::t_word r_out_front;
    deq_pkg::t_word r_out_rear;

    logic           in_accept;
    logic           finish;
    logic           full;
    logic           empty;
    logic           ram_we;
    deq_pkg::t_ptr  ram_waddr;
    logic           ram_re;
    deq_pkg::t_ptr  ram_raddr;
    deq_pkg::t_word ram_rdata;
    deq_pkg::t_word front_now;
    deq_pkg::t_word rear_now;
    logic [deq_pkg::CNT_W+deq_pkg::ENTRY_W-1:0] count_ext;

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = deq_pkg::S_FETCH;
                end
            end
            deq_pkg::S_FETCH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: n_state = deq_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        finish     = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            deq_pkg::S_FETCH: begin
                finish = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign full      = (r_count == deq_pkg::t_cnt'(deq_pkg::CAPACITY));
    assign empty     = (r_count == '0);

    // Pointer, count and cache updates when a request is accepted.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_rear      = r_rear;
        n_popped    = '0;
        n_pop_ok    = 1'b0;
        n_dropped   = 1'b0;
        n_fix_front = 1'b0;
        n_fix_rear  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = deq_pkg::ptr_dec(r_head);
        ram_re      = 1'b0;
        ram_raddr   = deq_pkg::ptr_inc(r_head);
        case (deq_pkg::t_action'(i_action))
            deq_pkg::ACT_PUSH_FRONT: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_head    = deq_pkg::ptr_dec(r_head);
                    n_count   = r_count + deq_pkg::t_cnt'(1);
                    n_front   = i_push_value;
                    ram_we    = in_accept;
                    ram_waddr = deq_pkg::ptr_dec(r_head);
                    if (empty) begin
                        n_rear = i_push_value;
                    end
                end
            end
            deq_pkg::ACT_PUSH_REAR: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_tail    = deq_pkg::ptr_inc(r_tail);
                    n_count   = r_count + deq_pkg::t_cnt'(1);
                    n_rear    = i_push_value;
                    ram_we    = in_accept;
                    ram_waddr = deq_pkg::ptr_inc(r_tail);
                    if (empty) begin
                        n_front = i_push_value;
                    end
                end
            end
            deq_pkg::ACT_POP_FRONT: begin
                if (!empty) begin
                    n_popped    = r_front;
                    n_pop_ok    = 1'b1;
                    n_head      = deq_pkg::ptr_inc(r_head);
                    n_count     = r_count - deq_pkg::t_cnt'(1);
                    n_fix_front = 1'b1;
                    ram_re      = in_accept;
                    ram_raddr   = deq_pkg::ptr_inc(r_head);
                end
            end
            deq_pkg::ACT_POP_REAR: begin
                if (!empty) begin
                    n_popped   = r_rear;
                    n_pop_ok   = 1'b1;
                    n_tail     = deq_pkg::ptr_dec(r_tail);
                    n_count    = r_count - deq_pkg::t_cnt'(1);
                    n_fix_rear = 1'b1;
                    ram_re     = in_accept;
                    ram_raddr  = deq_pkg::ptr_dec(r_tail);
                end
            end
            default: begin
                n_popped = '0;
            end
        endcase
    end

    // The cached end that a pop moved is refreshed from the RAM read data.
    assign front_now = r_fix_front ? ram_rdata : r_front;
    assign rear_now  = r_fix_rear ? ram_rdata : r_rear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= deq_pkg::t_ptr'(deq_pkg::CAPACITY - 1);
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_popped    <= n_popped;
            r_pop_ok    <= n_pop_ok;
            r_dropped   <= n_dropped;
            r_fix_front <= n_fix_front;
            r_fix_rear  <= n_fix_rear;
        end else if (finish) begin
            r_front <= front_now;
            r_rear  <= rear_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_popped  <= r_popped;
            r_out_pop_ok  <= r_pop_ok;
            r_out_dropped <= r_dropped;
            r_out_count   <= r_count;
            r_out_front   <= empty ? '0 : front_now;
            r_out_rear    <= empty ? '0 : rear_now;
        end
    end

    assign count_ext = {{deq_pkg::ENTRY_W{1'b0}}, r_out_count};

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_popped_ok    = r_out_pop_ok;
    assign o_push_dropped = r_out_dropped;
    assign o_entry_count  = count_ext[deq_pkg::ENTRY_W-1:0];
    assign o_is_empty     = (r_out_count == '0);
    assign o_front_value  = r_out_front;
    assign o_rear_value   = r_out_rear;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= deq_pkg::t_cnt'(deq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == deq_pkg::S_FETCH)
        else $error("accepted request did not enter fetch state");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !full && (i_action == deq_pkg::ACT_PUSH_FRONT ||
            i_action == deq_pkg::ACT_PUSH_REAR)
        |=> r_count == $past(r_count) + deq_pkg::t_cnt'(1))
        else $error("push did not grow the count by one");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && empty && i_action != deq_pkg::ACT_PUSH_FRONT &&
            i_action != deq_pkg::ACT_PUSH_REAR
        |=> r_count == '0 && !r_pop_ok)
        else $error("pop or status request on empty queue changed the count or popped");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_popped_ok && o_push_dropped))
        else $error("result reports both a pop and a dropped push");

endmodule
